FILE: sv/mbps_pkg.sv
// Shared constants and types of the masked byte pattern scanner.
package mbps_pkg;

  localparam int PAT_BYTES       = 16;
  localparam int MAX_PATTERN_DEF = 16;
  localparam int ADDR_W          = 48;
  localparam int LEN_W           = 5;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;

  localparam logic [CFG_IDX_W-1:0] REG_VALUE_LO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_LO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_HI  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REP_ALL  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd6;

  localparam logic [7:0] WILDCARD_MASK = 8'hFF;

  typedef struct packed {
    logic              report_all;
    logic [ADDR_W-1:0] base_adj;   // base + 1 - length
    logic [LEN_W-1:0]  len;        // clamped pattern length
  } cfg_t;

endpackage

FILE: sv/mbps_cfg.sv
// Configuration registers and the pattern aligned to the byte window.
module mbps_cfg #(
  parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic [MAX_PATTERN*8-1:0]         al_value_r,
  output logic [MAX_PATTERN*8-1:0]         al_mask_r,
  output logic [MAX_PATTERN-1:0]           al_en_r,
  output mbps_pkg::cfg_t                   cfg_r
);

  localparam int LW = mbps_pkg::LEN_W;
  localparam int AW = mbps_pkg::ADDR_W;

  logic [63:0]    value_lo_r, value_hi_r, mask_lo_r, mask_hi_r;
  logic [LW-1:0]  len_r;
  logic           rep_all_r;
  logic [AW-1:0]  base_r;

  logic [mbps_pkg::PAT_BYTES*8-1:0] pv, pm;
  logic [MAX_PATTERN*8-1:0]         rev_v, rev_m;
  logic [LW-1:0]                    len_c, sh;
  logic [MAX_PATTERN*8-1:0]         al_value_nxt, al_mask_nxt;
  logic [MAX_PATTERN-1:0]           al_en_nxt;
  mbps_pkg::cfg_t                   cfg_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_lo_r <= '0;
      value_hi_r <= '0;
      mask_lo_r  <= '0;
      mask_hi_r  <= '0;
      len_r      <= '0;
      rep_all_r  <= 1'b0;
      base_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mbps_pkg::REG_VALUE_LO: value_lo_r <= cfg_wdata;
        mbps_pkg::REG_VALUE_HI: value_hi_r <= cfg_wdata;
        mbps_pkg::REG_MASK_LO:  mask_lo_r  <= cfg_wdata;
        mbps_pkg::REG_MASK_HI:  mask_hi_r  <= cfg_wdata;
        mbps_pkg::REG_LENGTH:   len_r      <= cfg_wdata[LW-1:0];
        mbps_pkg::REG_REP_ALL:  rep_all_r  <= cfg_wdata[0];
        mbps_pkg::REG_BASE:     base_r     <= cfg_wdata[AW-1:0];
        default: ;
      endcase
    end
  end

  assign pv    = {value_hi_r, value_lo_r};
  assign pm    = {mask_hi_r, mask_lo_r};
  assign len_c = (len_r > LW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : len_r;
  assign sh    = LW'(MAX_PATTERN) - len_c;

  // Window slot k holds the byte k beats back; it meets pattern byte len-1-k.
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_align
    assign rev_v[k*8 +: 8] = pv[(MAX_PATTERN-1-k)*8 +: 8];
    assign rev_m[k*8 +: 8] = pm[(MAX_PATTERN-1-k)*8 +: 8];
    assign al_en_nxt[k]    = (LW'(k) < len_c);
  end

  always_comb begin
    al_value_nxt       = rev_v >> {sh, 3'b000};
    al_mask_nxt        = rev_m >> {sh, 3'b000};
    cfg_nxt.report_all = rep_all_r;
    cfg_nxt.len        = len_c;
    cfg_nxt.base_adj   = base_r + AW'(1) - AW'(len_c);
  end

  always_ff @(posedge clk) begin
    al_value_r <= al_value_nxt;
    al_mask_r  <= al_mask_nxt;
    al_en_r    <= al_en_nxt;
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: sv/mbps_match.sv
// Parallel masked compare of all window slots against the aligned pattern.
module mbps_match #(
  parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
  input  logic [MAX_PATTERN*8-1:0]       hist,
  input  logic [MAX_PATTERN*8-1:0]       al_value,
  input  logic [MAX_PATTERN*8-1:0]       al_mask,
  input  logic [MAX_PATTERN-1:0]         al_en,
  input  logic [mbps_pkg::LEN_W-1:0]     len,
  input  logic [mbps_pkg::LEN_W-1:0]     fill,
  output logic                           hit
);

  logic [MAX_PATTERN-1:0] miss;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cmp
    logic [7:0] m;
    assign m       = al_mask[k*8 +: 8];
    assign miss[k] = al_en[k] && (m != mbps_pkg::WILDCARD_MASK) &&
                     ((hist[k*8 +: 8] & ~m) != al_value[k*8 +: 8]);
  end

  // fill counts earlier bytes of this buffer; the current byte adds one
  assign hit = (len != '0) && ((fill + mbps_pkg::LEN_W'(1)) >= len) && (miss == '0);

endmodule

FILE: sv/masked_byte_pattern_scanner_top.sv
// Top level of the masked byte pattern scanner.
// One buffer byte is taken per clock, back to back; a result leaves the result register once
// its byte has passed the input register, then the compare and result register. All
// pattern positions are compared in parallel against a shift window of earlier bytes, so the
// rate is one byte per cycle whenever out_tready is high. A configuration write takes effect
// for bytes accepted from the next cycle on. No clearing pass is needed after reset.
module masked_byte_pattern_scanner_top #(
  parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] data_byte
  input  logic                             in_tlast,   // last_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mbps_pkg::ADDR_W-1:0]      out_tdata,  // [47:0] match_address
  output logic                             out_tuser,  // found
  output logic                             out_tlast   // buffer_done
);

  localparam int AW     = mbps_pkg::ADDR_W;
  localparam int LW     = mbps_pkg::LEN_W;
  localparam int FILL_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [MAX_PATTERN*8-1:0] al_value, al_mask;
  logic [MAX_PATTERN-1:0]   al_en;
  mbps_pkg::cfg_t           cfg;

  logic             in_v_r, in_v_nxt;
  logic [7:0]       in_data_r;
  logic             in_last_r;
  logic             out_v_r, out_v_nxt;
  logic [AW-1:0]    out_addr_r;
  logic             out_found_r, out_done_r;

  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [AW-1:0]     off_r, off_nxt;
  logic              hit_rep_r, hit_rep_nxt;

  logic                     adv, in_fire, s1_fire;
  logic [MAX_PATTERN*8-1:0] hist;
  logic                     hit, report, not_found;

  mbps_cfg #(.MAX_PATTERN(MAX_PATTERN)) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .al_value_r (al_value),
    .al_mask_r  (al_mask),
    .al_en_r    (al_en),
    .cfg_r      (cfg)
  );

  // byte window: slot 0 is the current byte, slot k the byte k beats back
  if (MAX_PATTERN > 1) begin : g_win
    logic [(MAX_PATTERN-1)*8-1:0] win_r;
    assign hist = {win_r, in_data_r};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        win_r <= '0;
      end else if (s1_fire) begin
        win_r <= hist[(MAX_PATTERN-1)*8-1:0];
      end
    end
  end else begin : g_nowin
    assign hist = in_data_r;
  end

  mbps_match #(.MAX_PATTERN(MAX_PATTERN)) u_match (
    .hist     (hist),
    .al_value (al_value),
    .al_mask  (al_mask),
    .al_en    (al_en),
    .len      (cfg.len),
    .fill     (LW'(fill_r)),
    .hit      (hit)
  );

  assign adv       = !out_v_r || out_tready;
  assign in_tready = !in_v_r || adv;
  assign in_fire   = in_tvalid && in_tready;
  assign s1_fire   = in_v_r && adv;

  assign report    = hit && (cfg.report_all || !hit_rep_r);
  assign not_found = in_last_r && !hit_rep_r && !report;

  always_comb begin
    in_v_nxt    = in_fire || (in_v_r && !adv);
    out_v_nxt   = adv ? (in_v_r && (report || not_found)) : out_v_r;
    fill_nxt    = fill_r;
    off_nxt     = off_r;
    hit_rep_nxt = hit_rep_r;
    if (s1_fire) begin
      if (in_last_r) begin
        fill_nxt    = '0;
        off_nxt     = '0;
        hit_rep_nxt = 1'b0;
      end else begin
        if (fill_r < FILL_W'(MAX_PATTERN-1)) begin
          fill_nxt = fill_r + FILL_W'(1);
        end
        off_nxt     = off_r + AW'(1);
        hit_rep_nxt = hit_rep_r || report;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      fill_r    <= '0;
      off_r     <= '0;
      hit_rep_r <= 1'b0;
    end else begin
      in_v_r    <= in_v_nxt;
      out_v_r   <= out_v_nxt;
      fill_r    <= fill_nxt;
      off_r     <= off_nxt;
      hit_rep_r <= hit_rep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (s1_fire) begin
      out_addr_r  <= report ? (cfg.base_adj + off_r) : '0;
      out_found_r <= report;
      out_done_r  <= in_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_done_r;

endmodule

FILE: sv/mbps_checker.sv
// Port-level assertions of the scanner top level, with their bind.
module mbps_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [mbps_pkg::ADDR_W-1:0]  out_tdata,
  input logic                         out_tuser,
  input logic                         out_tlast
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // not-found is only given at the end of a buffer and carries a zero address
  a_nf_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && (out_tdata == '0))
    else $error("not-found result outside buffer end or with address");

  // a fresh result must be preceded by an accepted input beat
  a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result appeared without a preceding input beat");

endmodule

bind masked_byte_pattern_scanner_top mbps_checker u_mbps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

FILE: sim/masked_byte_pattern_scanner_top_tb.sv
// Self-checking testbench for the masked byte pattern scanner: directed and random buffers.
module masked_byte_pattern_scanner_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADDR_W     = mbps_pkg::ADDR_W;
  localparam int LEN_W      = mbps_pkg::LEN_W;
  localparam int PAT_BYTES  = mbps_pkg::PAT_BYTES;
  localparam int CFG_IDX_W  = mbps_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = mbps_pkg::CFG_DATA_W;

  localparam int CLK_HALF     = 6;
  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_REPORTED = 10;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              found;
    logic              done;
  } scan_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;   // [7:0] data_byte
  logic                  in_tlast;   // last_byte
  logic                  out_tvalid;
  logic                  out_tready;
  logic [ADDR_W-1:0]     out_tdata;  // [47:0] match_address
  logic                  out_tuser;  // found
  logic                  out_tlast;  // buffer_done

  masked_byte_pattern_scanner_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // scanner model state and its copy of the registers
  logic [127:0]      pat_val    = '0;
  logic [127:0]      pat_mask   = '0;
  logic [LEN_W-1:0]  pat_len    = '0;
  logic              rep_all    = 1'b0;
  logic [ADDR_W-1:0] base_addr  = '0;
  logic [7:0]        win [PAT_BYTES-1] = '{default: 8'h00};
  int                win_fill   = 0;
  logic [ADDR_W-1:0] scan_off   = '0;
  logic              hit_seen   = 1'b0;

  scan_result_t expected_q[$];
  int           error_count = 0;
  int           bytes_sent  = 0;
  int           cycle_count = 0;
  int           src_idle_pct;
  int           sink_idle_pct;
  int           hold_cycles;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Work out the result (if any) of one accepted byte and advance the window.
  function automatic void predict_scan(input logic [7:0] data_b, input logic last_b);
    int                eff_len;
    int                j;
    int                back;
    logic              hit;
    logic [7:0]        wb;
    logic [7:0]        v;
    logic [7:0]        m;
    logic [ADDR_W-1:0] start;
    scan_result_t      r;
    eff_len = (pat_len > PAT_BYTES) ? PAT_BYTES : int'(pat_len);
    hit = (eff_len != 0) && (win_fill + 1 >= eff_len);
    for (j = 0; j < eff_len; j++) begin
      back = eff_len - 1 - j;
      wb = (back == 0) ? data_b : win[back-1];
      v = pat_val[8*j +: 8];
      m = pat_mask[8*j +: 8];
      if (m != mbps_pkg::WILDCARD_MASK && ((wb & ~m) != v))
        hit = 1'b0;
    end
    if (hit && (rep_all || !hit_seen)) begin
      start = scan_off - ADDR_W'(eff_len - 1);
      r.addr = base_addr + start;
      r.found = 1'b1;
      r.done = last_b;
      hit_seen = 1'b1;
      expected_q = {expected_q, r};
    end else if (last_b && !hit_seen) begin
      r.addr = '0;
      r.found = 1'b0;
      r.done = 1'b1;
      expected_q = {expected_q, r};
    end
    for (j = PAT_BYTES - 2; j > 0; j--)
      win[j] = win[j-1];
    win[0] = data_b;
    if (last_b) begin
      win_fill = 0;
      scan_off = '0;
      hit_seen = 1'b0;
    end else begin
      if (win_fill < PAT_BYTES - 1)
        win_fill++;
      scan_off = scan_off + 1'b1;
    end
  endfunction

  task automatic check_scan_result();
    scan_result_t exp_r;
    if (expected_q.size() == 0) begin
      error_count++;
      if (error_count <= MAX_REPORTED)
        $display("%0t: unexpected result addr=%h found=%b done=%b", $realtime, out_tdata,
                 out_tuser, out_tlast);
    end else begin
      exp_r = expected_q.pop_front();
      if (out_tdata !== exp_r.addr || out_tuser !== exp_r.found || out_tlast !== exp_r.done)
      begin
        error_count++;
        if (error_count <= MAX_REPORTED)
          $display("%0t: mismatch exp addr=%h found=%b done=%b, got addr=%h found=%b done=%b",
                   $realtime, exp_r.addr, exp_r.found, exp_r.done, out_tdata, out_tuser,
                   out_tlast);
      end
    end
  endtask

  // result side: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      check_scan_result();
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      mbps_pkg::REG_VALUE_LO: pat_val[63:0] = data;
      mbps_pkg::REG_VALUE_HI: pat_val[127:64] = data;
      mbps_pkg::REG_MASK_LO:  pat_mask[63:0] = data;
      mbps_pkg::REG_MASK_HI:  pat_mask[127:64] = data;
      mbps_pkg::REG_LENGTH:   pat_len = data[LEN_W-1:0];
      mbps_pkg::REG_REP_ALL:  rep_all = data[0];
      mbps_pkg::REG_BASE:     base_addr = data[ADDR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] data_b, input logic last_b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= data_b;
    in_tlast <= last_b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    predict_scan(data_b, last_b);
  endtask

  // Stop offering beats, wait for every result, then let the pipe empty.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_pattern(input logic [127:0] val, input logic [127:0] msk,
                              input logic [63:0] len_word, input logic [63:0] all_word,
                              input logic [63:0] base_word);
    write_reg(mbps_pkg::REG_VALUE_LO, val[63:0]);
    write_reg(mbps_pkg::REG_VALUE_HI, val[127:64]);
    write_reg(mbps_pkg::REG_MASK_LO, msk[63:0]);
    write_reg(mbps_pkg::REG_MASK_HI, msk[127:64]);
    write_reg(mbps_pkg::REG_LENGTH, len_word);
    write_reg(mbps_pkg::REG_REP_ALL, all_word);
    write_reg(mbps_pkg::REG_BASE, base_word);
  endtask

  // reset config: length zero never matches, so the buffer ends not-found
  task automatic test_length_zero();
    send_byte(8'h00, 1'b1);
    wait_idle();
  endtask

  // 12 ?? 3x FF with first-hit reporting, a base near the top of the address space and buffer boundaries
  task automatic test_masked_first_hit();
    load_pattern({64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_FF30_0012},
                 {64'h0000_0000_0000_0000, 64'h0000_0000_000F_FF00},
                 64'd4, 64'd0, 64'h0000_FFFF_FFFF_FFFE);
    send_byte(8'h12, 1'b0);
    send_byte(8'hAB, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h35, 1'b0);
    send_byte(8'hFF, 1'b1);  // second hit on last byte: suppressed, no result
    // pattern split over two buffers must not match
    send_byte(8'h12, 1'b0);
    send_byte(8'h77, 1'b1);
    send_byte(8'h30, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();
  endtask

  // length 31 is used as 16; only the top pattern byte is not a wildcard
  task automatic test_clamped_length_all();
    int i;
    load_pattern({64'hA500_0000_0000_0000, 64'h0000_0000_0000_0000},
                 {64'h00FF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
                 64'd31, 64'd1, 64'd0);
    for (i = 0; i < PAT_BYTES - 1; i++)
      send_byte(i[0] ? 8'hFF : 8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'hA5, 1'b1);
    wait_idle();
  endtask

  // every byte hits; a long hold on the result side must stall the input
  task automatic test_backpressure();
    int i;
    load_pattern('0, {128{1'b1}}, 64'd1, 64'd1, {16'h0, 16'($urandom), 32'($urandom)});
    hold_cycles <= 300;
    for (i = 0; i < 80; i++)
      send_byte(8'($urandom), (i == 79) || ($urandom_range(0, 15) == 0));
    wait_idle();
  endtask

  task automatic program_random_pattern(input int round);
    logic [127:0] val;
    logic [127:0] msk;
    logic [63:0]  len_word;
    logic [63:0]  all_word;
    logic [63:0]  base_word;
    logic [7:0]   m;
    int           j;
    for (j = 0; j < PAT_BYTES; j++) begin
      case ($urandom_range(0, 3))
        0:       m = 8'h00;
        1:       m = mbps_pkg::WILDCARD_MASK;
        2:       m = 8'($urandom);
        default: m = 8'h00;
      endcase
      msk[8*j +: 8] = m;
      // now and then leave value bits under the mask: such a byte never matches unless its mask is the wildcard
      val[8*j +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : (8'($urandom) & ~m);
    end
    len_word = {32'($urandom), 32'($urandom)};
    case (round % 6)
      0:       len_word[LEN_W-1:0] = '0;
      1:       len_word[LEN_W-1:0] = 5'd1;
      2:       len_word[LEN_W-1:0] = 5'd16;
      3:       len_word[LEN_W-1:0] = LEN_W'($urandom_range(17, 31));
      default: len_word[LEN_W-1:0] = LEN_W'($urandom_range(2, 8));
    endcase
    all_word = {32'($urandom), 32'($urandom)};
    case (round % 4)
      1:       base_word = '0;
      2:       base_word = '1;
      default: base_word = {32'($urandom), 32'($urandom)};
    endcase
    load_pattern(val, msk, len_word, all_word, base_word);
  endtask

  task automatic send_random_buffer();
    logic [7:0] byte_q[$];
    int         target;
    int         eff_len;
    int         j;
    int         flip;
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 20);
    eff_len = (pat_len > PAT_BYTES) ? PAT_BYTES : int'(pat_len);
    while (byte_q.size() < target) begin
      if (eff_len != 0 && $urandom_range(0, 2) == 0) begin
        // planted occurrence, sometimes with one bit of one byte flipped
        flip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, eff_len - 1) : -1;
        for (j = 0; j < eff_len; j++)
          byte_q = {byte_q, (pat_val[8*j +: 8] | (8'($urandom) & pat_mask[8*j +: 8])) ^
                            ((j == flip) ? 8'(1 << $urandom_range(0, 7)) : 8'h00)};
      end else if ($urandom_range(0, 1) == 0) begin
        byte_q = {byte_q, pat_val[8*$urandom_range(0, PAT_BYTES - 1) +: 8]};
      end else begin
        byte_q = {byte_q, 8'($urandom)};
      end
    end
    for (j = 0; j < byte_q.size(); j++)
      send_byte(byte_q[j], j == byte_q.size() - 1);
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_bytes);
    int stop_at;
    int round;
    src_idle_pct = src_pct;
    sink_idle_pct <= sink_pct;
    stop_at = bytes_sent + n_bytes;
    round = 0;
    while (bytes_sent < stop_at) begin
      program_random_pattern(round);
      repeat ($urandom_range(2, 5)) send_random_buffer();
      wait_idle();
      round++;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    src_idle_pct = 0;
    sink_idle_pct = 0;
    hold_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_length_zero();
    test_masked_first_hit();
    test_clamped_length_all();
    test_backpressure();
    test_random_traffic(33, 65, 500);
    test_random_traffic(65, 33, 500);
    test_random_traffic(0, 0, 500);

    wait_idle();
    error_count += expected_q.size();
    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: masked_byte_pattern_scanner_top.f
sv/mbps_pkg.sv
sv/mbps_cfg.sv
sv/mbps_match.sv
sv/masked_byte_pattern_scanner_top.sv
sv/mbps_checker.sv
sim/masked_byte_pattern_scanner_top_tb.sv
